### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a named clock and active-low reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

### hw/rtl/adhf_pkg.sv
package adhf_pkg;

  // frame store geometry
  localparam int MAX_ROWS    = 512;
  localparam int MAX_COLS    = 1024;
  localparam int MAX_RADIUS  = 15;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int ROW_W    = 9;
  localparam int COL_W    = 10;
  localparam int DEPTH_W  = 16;
  localparam int RADIUS_W = 4;
  localparam int MAXD_W   = 16;
  localparam int ROWS_W   = 10;
  localparam int COLS_W   = 11;
  localparam int CIDX_W   = 2;
  localparam int CDATA_W  = 16;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // weight table shape, indexed by {|di|, |dj|}
  localparam int NRAD  = 1 << RADIUS_W;
  localparam int TAB_N = 1 << (2 * RADIUS_W);

  // item kinds
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ROWS_IN_USE  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_COLS_IN_USE  = 2'd2;

  // register reset values
  localparam logic [MAXD_W-1:0] MAXD_RST = 16'd25600;
  localparam logic [ROWS_W-1:0] ROWS_RST = 10'd512;
  localparam logic [COLS_W-1:0] COLS_RST = 11'd1024;

  // effective configuration (saturated, zero range mapped to one)
  typedef struct packed {
    logic [MAXD_W-1:0] maxd;
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic               func;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [DEPTH_W-1:0] din;
    logic               border;
  } cmd_t;

  typedef logic [TAB_N-1:0][DEPTH_W-1:0] wrow_t;
  typedef logic [NRAD-1:0][TAB_N-1:0][DEPTH_W-1:0] gtab_t;

  // shift-subtract division, elaboration use only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // integer square root, elaboration use only
  function automatic logic [63:0] isqrt_u64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = val;
    res = '0;
    bt  = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - res - bt;
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // rounded 65536/sqrt(d2), saturated
  function automatic logic [DEPTH_W-1:0] inv_w(input logic [63:0] d2);
    logic [63:0] w;
    if (d2 == 0) return 16'hFFFF;
    w = (isqrt_u64(div_u64(64'h1 << 34, d2)) + 64'd1) >> 1;
    return (w > 64'd65535) ? 16'hFFFF : w[DEPTH_W-1:0];
  endfunction

  // truncated Taylor series of 65536*exp(-d2/(2r^2))
  function automatic logic [DEPTH_W-1:0] gauss_w(input logic [63:0] d2, input logic [63:0] r);
    logic [63:0] b;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] v;
    b    = 64'd2 * r * r;
    term = 64'h1 << 40;
    pos  = term;
    neg  = '0;
    if (b == 0) return '0;
    for (int k = 1; k <= 24; k++) begin
      term = div_u64(term * d2, b * 64'(k));
      if (k % 2 == 1) neg = neg + term;
      else pos = pos + term;
    end
    v = (pos > neg) ? pos - neg : 64'd0;
    v = (v + (64'h1 << 23)) >> 24;
    return (v > 64'd65535) ? 16'hFFFF : v[DEPTH_W-1:0];
  endfunction

  function automatic wrow_t build_inv();
    wrow_t t;
    for (int a = 0; a < NRAD; a++) begin
      for (int b = 0; b < NRAD; b++) begin
        t[a * NRAD + b] = inv_w(64'(a * a + b * b));
      end
    end
    return t;
  endfunction

  function automatic gtab_t build_gauss();
    gtab_t t;
    for (int r = 0; r < NRAD; r++) begin
      for (int a = 0; a < NRAD; a++) begin
        for (int b = 0; b < NRAD; b++) begin
          if (a * a + b * b <= 2 * r * r)
            t[r][a * NRAD + b] = gauss_w(64'(a * a + b * b), 64'(r));
          else
            t[r][a * NRAD + b] = '0;
        end
      end
    end
    return t;
  endfunction

  localparam wrow_t INV_TAB   = build_inv();
  localparam gtab_t GAUSS_TAB = build_gauss();

endpackage

### hw/rtl/adhf_ram.sv
module adhf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/adhf_front.sv
module adhf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [adhf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adhf_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [adhf_pkg::CDATA_W-1:0]        cfg_data_i,
  output adhf_pkg::cfg_t                      cfg_o,
  output logic                                q_valid_o,
  output adhf_pkg::cmd_t                      q_cmd_o,
  input  logic                                q_pop_i
);

  import adhf_pkg::*;

  localparam int QDEPTH = 2;

  logic [MAXD_W-1:0] maxd_q;
  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;

  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic [DEPTH_W-1:0] in_din;
  logic               in_border;
  logic               push;

  cmd_t       q_mem_q [QDEPTH];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxd_q <= MAXD_RST;
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAX_DISTANCE: maxd_q <= cfg_data_i[MAXD_W-1:0];
        REG_ROWS_IN_USE:  rows_q <= cfg_data_i[ROWS_W-1:0];
        REG_COLS_IN_USE:  cols_q <= cfg_data_i[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate frame size to the store, zero range counts as one
  assign rows_eff = (rows_q > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : rows_q;
  assign cols_eff = (cols_q > COLS_W'(MAX_COLS)) ? COLS_W'(MAX_COLS) : cols_q;
  assign cfg_o.maxd = (maxd_q == '0) ? MAXD_W'(1) : maxd_q;
  assign cfg_o.rows = rows_eff;
  assign cfg_o.cols = cols_eff;

  // unpack and classify by position
  assign in_row = s_axis_tdata[ROW_W-1:0];
  assign in_col = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign in_din = s_axis_tdata[ROW_W+COL_W+DEPTH_W-1:ROW_W+COL_W];

  assign in_border = (ROWS_W'(in_row) >= rows_eff) || (COLS_W'(in_col) >= cols_eff) ||
                     (in_row == '0) || (in_col == '0) ||
                     (ROWS_W'(in_row) + ROWS_W'(1) == rows_eff) ||
                     (COLS_W'(in_col) + COLS_W'(1) == cols_eff);

  // short queue toward the back
  assign s_axis_tready = (count_q != 2'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (count_q != 2'd0);
  assign q_cmd_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= '{func: s_axis_tuser, row: in_row, col: in_col,
                             din: in_din, border: in_border};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, q_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hw/rtl/adhf_back.sv
`include "assert_macros.svh"

module adhf_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  adhf_pkg::cfg_t                      cfg_i,
  input  logic                                q_valid_i,
  input  adhf_pkg::cmd_t                      q_cmd_i,
  output logic                                q_pop_o,
  output logic                                ram_we_o,
  output logic [adhf_pkg::ADDR_W-1:0]         ram_waddr_o,
  output logic [adhf_pkg::DEPTH_W-1:0]        ram_wdata_o,
  output logic [adhf_pkg::ADDR_W-1:0]         ram_raddr_o,
  input  logic [adhf_pkg::DEPTH_W-1:0]        ram_rdata_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [adhf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser
);

  import adhf_pkg::*;

  localparam int OFF_W  = RADIUS_W + 1;
  localparam int POS_W  = 13;
  localparam int S_W    = 21;
  localparam int C_W    = 5;
  localparam int MC_W   = 21;
  localparam int CMP_W  = 26;
  localparam int WSUM_W = 43;
  localparam int WTOT_W = 26;
  localparam int PROD_W = 2 * DEPTH_W;
  localparam logic [RADIUS_W-1:0] R_NEAR = RADIUS_W'(3);
  localparam logic [RADIUS_W-1:0] R_MED  = RADIUS_W'(5);
  localparam logic [RADIUS_W-1:0] K_MAX  = RADIUS_W'(MAX_RADIUS - 3);
  localparam logic [OFF_W-1:0]    NB_LIM = OFF_W'(2);

  typedef enum logic [3:0] {
    S_IDLE, S_CTR, S_NB, S_NBW, S_MC, S_CMP, S_RAD, S_WIN, S_WDRN, S_DIV, S_OUT
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;

  logic signed [OFF_W-1:0] di_q, dj_q;
  logic [RADIUS_W-1:0] rad_q, k_q, bit_q;
  logic [S_W-1:0]      s_q;
  logic [C_W-1:0]      c_q;
  logic [MC_W-1:0]     mc_q;
  logic [CMP_W-1:0]    acc_q;
  logic                gauss_q;
  logic [WSUM_W-1:0]   wsum_q, rem_q;
  logic [WTOT_W-1:0]   wtot_q;
  logic [DEPTH_W-1:0]  quo_q;
  logic [2:0]          drn_q;
  logic [DEPTH_W-1:0]  res_depth_q;
  logic                res_fill_q;
  logic [RADIUS_W-1:0] res_rad_q;
  logic                out_valid_q;
  logic [DEPTH_W-1:0]  out_depth_q;
  logic                out_fill_q;
  logic [RADIUS_W-1:0] out_rad_q;

  // read tag pipeline and weight pipeline
  logic                tag_v_q, tag_nb_q, tag_win_q;
  logic [RADIUS_W-1:0] tag_a_q, tag_b_q;
  logic                v1_q, v2_q, v3_q;
  logic [DEPTH_W-1:0]  p1_q, p2_q, inv1_q, w2_q, wt3_q;
  logic [DEPTH_W-1:0]  gc_q [NRAD];
  logic [DEPTH_W-1:0]  gc_d [NRAD];
  logic [PROD_W-1:0]   prod_q;

  logic signed [POS_W-1:0] ni, nj;
  logic                    in_frame;
  logic [OFF_W-1:0]        lim;
  logic                    last_col, last_pos;
  logic                    walk;
  logic [RADIUS_W-1:0]     abs_di, abs_dj;
  logic [2*RADIUS_W-1:0]   tab_idx;
  logic [CMP_W-1:0]        s10, s6, mc4, mc6, mc7;
  logic [WSUM_W-1:0]       den_sh;
  logic                    out_free;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  // neighbour position and frame clipping
  assign ni = $signed(POS_W'(cmd_q.row)) + POS_W'(di_q);
  assign nj = $signed(POS_W'(cmd_q.col)) + POS_W'(dj_q);
  assign in_frame = !ni[POS_W-1] && !nj[POS_W-1] &&
                    (ni[POS_W-2:0] < (POS_W-1)'(cfg_i.rows)) &&
                    (nj[POS_W-2:0] < (POS_W-1)'(cfg_i.cols));

  // window scan order, row by row
  assign walk     = (state_q == S_NB) || (state_q == S_WIN);
  assign lim      = (state_q == S_NB) ? NB_LIM : OFF_W'(rad_q);
  assign last_col = (dj_q == $signed(lim));
  assign last_pos = last_col && (di_q == $signed(lim));
  assign abs_di   = di_q[OFF_W-1] ? RADIUS_W'(-di_q) : RADIUS_W'(di_q);
  assign abs_dj   = dj_q[OFF_W-1] ? RADIUS_W'(-dj_q) : RADIUS_W'(dj_q);

  // store port
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign ram_we_o    = q_pop_o && (q_cmd_i.func == FUNC_LOAD);
  assign ram_waddr_o = addr_of(q_cmd_i.row, q_cmd_i.col);
  assign ram_wdata_o = q_cmd_i.din;
  assign ram_raddr_o = (state_q == S_IDLE) ? addr_of(q_cmd_i.row, q_cmd_i.col)
                                           : addr_of(ni[ROW_W-1:0], nj[COL_W-1:0]);

  // weight lookups for every radius at one offset
  assign tab_idx = {tag_a_q, tag_b_q};
  always_comb begin
    for (int rr = 0; rr < NRAD; rr++) gc_d[rr] = GAUSS_TAB[rr][tab_idx];
  end

  // region thresholds
  assign s10 = (CMP_W'(s_q) << 3) + (CMP_W'(s_q) << 1);
  assign s6  = (CMP_W'(s_q) << 2) + (CMP_W'(s_q) << 1);
  assign mc4 = CMP_W'(mc_q) << 2;
  assign mc6 = mc4 + (CMP_W'(mc_q) << 1);
  assign mc7 = mc6 + CMP_W'(mc_q);

  assign den_sh   = WSUM_W'(wtot_q) << bit_q;
  assign out_free = !out_valid_q || m_axis_tready;

  // payload pipeline from read data to product
  always_ff @(posedge clk_i) begin
    tag_a_q <= abs_di;
    tag_b_q <= abs_dj;
    p1_q    <= ram_rdata_i;
    inv1_q  <= INV_TAB[tab_idx];
    for (int rr = 0; rr < NRAD; rr++) gc_q[rr] <= gc_d[rr];
    p2_q    <= p1_q;
    w2_q    <= gauss_q ? gc_q[rad_q] : inv1_q;
    prod_q  <= p2_q * w2_q;
    wt3_q   <= w2_q;
  end

  // sequencer, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      di_q        <= '0;
      dj_q        <= '0;
      rad_q       <= '0;
      k_q         <= '0;
      bit_q       <= '0;
      s_q         <= '0;
      c_q         <= '0;
      mc_q        <= '0;
      acc_q       <= '0;
      gauss_q     <= 1'b0;
      wsum_q      <= '0;
      wtot_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      drn_q       <= '0;
      res_depth_q <= '0;
      res_fill_q  <= 1'b0;
      res_rad_q   <= '0;
      out_valid_q <= 1'b0;
      out_depth_q <= '0;
      out_fill_q  <= 1'b0;
      out_rad_q   <= '0;
      tag_v_q     <= 1'b0;
      tag_nb_q    <= 1'b0;
      tag_win_q   <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      // read tags travel with the registered store output
      tag_v_q   <= walk && in_frame;
      tag_nb_q  <= (state_q == S_NB);
      tag_win_q <= (state_q == S_WIN);
      v1_q      <= tag_v_q && tag_win_q && (ram_rdata_i != '0);
      v2_q      <= v1_q;
      v3_q      <= v2_q;

      // 5x5 neighbourhood sum and count
      if (tag_v_q && tag_nb_q && (ram_rdata_i != '0)) begin
        s_q <= s_q + S_W'(ram_rdata_i);
        c_q <= c_q + C_W'(1);
      end

      // weighted sums
      if (v3_q) begin
        wsum_q <= wsum_q + WSUM_W'(prod_q);
        wtot_q <= wtot_q + WTOT_W'(wt3_q);
      end

      // output register drains independently, unless reloaded below
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) out_valid_q <= 1'b0;

      // step through the window
      if (walk) begin
        if (last_col) begin
          dj_q <= -$signed(lim);
          di_q <= di_q + OFF_W'(1);
        end else begin
          dj_q <= dj_q + OFF_W'(1);
        end
      end

      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cmd_q <= q_cmd_i;
            if (q_cmd_i.func == FUNC_LOAD) begin
              res_depth_q <= q_cmd_i.din;
              res_fill_q  <= 1'b0;
              res_rad_q   <= '0;
              state_q     <= S_OUT;
            end else begin
              state_q <= S_CTR;
            end
          end
        end
        S_CTR: begin
          if (cmd_q.border || (ram_rdata_i != '0)) begin
            res_depth_q <= ram_rdata_i;
            res_fill_q  <= 1'b0;
            res_rad_q   <= '0;
            state_q     <= S_OUT;
          end else begin
            di_q    <= -$signed(NB_LIM);
            dj_q    <= -$signed(NB_LIM);
            s_q     <= '0;
            c_q     <= '0;
            state_q <= S_NB;
          end
        end
        S_NB: begin
          if (last_pos) state_q <= S_NBW;
        end
        S_NBW: state_q <= S_MC;
        S_MC: begin
          if (c_q == '0) begin
            res_depth_q <= '0;
            res_fill_q  <= 1'b0;
            res_rad_q   <= '0;
            state_q     <= S_OUT;
          end else begin
            mc_q    <= MC_W'(cfg_i.maxd) * MC_W'(c_q);
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          gauss_q <= (s10 > mc6);
          wsum_q  <= '0;
          wtot_q  <= '0;
          if (s10 > mc7) begin
            acc_q   <= CMP_W'(mc_q);
            k_q     <= '0;
            state_q <= S_RAD;
          end else begin
            rad_q   <= (s10 > mc4) ? R_MED : R_NEAR;
            di_q    <= (s10 > mc4) ? -$signed(OFF_W'(R_MED)) : -$signed(OFF_W'(R_NEAR));
            dj_q    <= (s10 > mc4) ? -$signed(OFF_W'(R_MED)) : -$signed(OFF_W'(R_NEAR));
            state_q <= S_WIN;
          end
        end
        S_RAD: begin
          // quotient by repeated add, capped at the largest radius
          if ((k_q != K_MAX) && (acc_q <= s6)) begin
            k_q   <= k_q + RADIUS_W'(1);
            acc_q <= acc_q + CMP_W'(mc_q);
          end else begin
            rad_q   <= R_NEAR + k_q;
            di_q    <= -$signed(OFF_W'(R_NEAR + k_q));
            dj_q    <= -$signed(OFF_W'(R_NEAR + k_q));
            state_q <= S_WIN;
          end
        end
        S_WIN: begin
          if (last_pos) begin
            drn_q   <= '0;
            state_q <= S_WDRN;
          end
        end
        S_WDRN: begin
          // wait for the weight pipeline to empty
          if (drn_q == 3'd4) begin
            if (wtot_q == '0) begin
              res_depth_q <= '0;
              res_fill_q  <= 1'b0;
              res_rad_q   <= '0;
              state_q     <= S_OUT;
            end else begin
              rem_q   <= wsum_q + WSUM_W'(wtot_q >> 1);
              quo_q   <= '0;
              bit_q   <= RADIUS_W'(DEPTH_W - 1);
              state_q <= S_DIV;
            end
          end else begin
            drn_q <= drn_q + 3'd1;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          if (rem_q >= den_sh) begin
            rem_q        <= rem_q - den_sh;
            quo_q[bit_q] <= 1'b1;
          end
          if (bit_q == '0) begin
            res_depth_q <= (rem_q >= den_sh) ? (quo_q | DEPTH_W'(1)) : quo_q;
            res_fill_q  <= 1'b1;
            res_rad_q   <= rad_q;
            state_q     <= S_OUT;
          end else begin
            bit_q <= bit_q - RADIUS_W'(1);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_depth_q <= res_depth_q;
            out_fill_q  <= res_fill_q;
            out_rad_q   <= res_rad_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-DEPTH_W-RADIUS_W)'(0), out_rad_q, out_depth_q};
  assign m_axis_tuser  = out_fill_q;

  // filled results always carry a real window radius
  `ASSERT_CLK(a_fill_rad, (out_valid_q && out_fill_q) |-> (out_rad_q >= R_NEAR), "filled radius")
  // unfilled results report no window
  `ASSERT_CLK(a_nofill_rad, (out_valid_q && !out_fill_q) |-> (out_rad_q == '0), "radius not 0")
  // store is never written while a window is being read
  `ASSERT_CLK(a_walk_nowr, walk |-> !ram_we_o, "store write during walk")

endmodule

### hw/rtl/adaptive_depth_hole_fill_unit.sv
// load: the input depth is returned as the result; border or nonzero compute: the stored depth is returned
// hole fill: a square window of radius 3 or 5, or of up to radius 15 at far range;
// output stalls delay the result
// one item is worked at a time; the single read port of the frame store sets the walk
// a two-entry queue and an output register let input and output transfers overlap work
// reset clears configuration to defaults and all control; the frame store is not cleared
module adaptive_depth_hole_fill_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // row[8:0], col[18:9], depth_in[34:19], zero fill [39:35]
  input  logic [adhf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // depth_out[15:0], window_radius[19:16], zero fill [23:20]
  output logic [adhf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // was_filled
  output logic                                m_axis_tuser,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [adhf_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [adhf_pkg::CDATA_W-1:0]        cfg_data_i
);

  import adhf_pkg::*;

  cfg_t               cfg;
  cmd_t               q_cmd;
  logic               q_valid;
  logic               q_pop;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DEPTH_W-1:0] ram_wdata;
  logic [DEPTH_W-1:0] ram_rdata;

  // accept, configure and classify
  adhf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_o         (cfg),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd),
    .q_pop_i       (q_pop)
  );

  // execute loads and hole fills
  adhf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // frame store
  adhf_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
